>>> src/dead_time_duty_compensation_defines.svh
// Assertion macros for the dead-time duty compensation block.
// Used by the port checker; no other dependencies.
`ifndef DEAD_TIME_DUTY_COMPENSATION_DEFINES_SVH
`define DEAD_TIME_DUTY_COMPENSATION_DEFINES_SVH

// Clocked assertion, quiet while reset is high.
`define DTDC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also checks across reset.
`define DTDC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/dtdc_pkg.sv
// Shared types, constants and tables for the dead-time duty compensation block.
// No dependencies.
`default_nettype none

package dtdc_pkg;

  localparam int ANGLE_BITS  = 16;
  localparam int TRIG_STAGES = 16;
  localparam int STAGE_W     = (TRIG_STAGES > 1) ? $clog2(TRIG_STAGES) : 1;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 32;

  localparam logic signed [31:0] CORDIC_X0      = 32'sd652032874;
  localparam logic signed [31:0] SQRT3_HALF_Q30 = 32'sd929887697;

  typedef logic [ANGLE_BITS-1:0] angle_t;
  typedef logic [STAGE_W-1:0]    stage_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEAD_TIME_DUTY   = 8'd0,
    REG_SPEED_THRESHOLD  = 8'd1,
    REG_LEAD_GAIN        = 8'd2,
    REG_CURRENT_DEADBAND = 8'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
  } duty_t;

  typedef struct packed {
    logic signed [15:0] current_d;
    logic signed [15:0] current_q;
    duty_t              duty;
    logic               comp_en;
  } side_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               flip;
    side_t              side;
  } cord_t;

  // Arctangent of 2^-i, 2^32 is one full turn.
  function automatic logic signed [31:0] atan_turn(input stage_t i);
    logic signed [31:0] v;
    case (int'(i))
      0:       v = 32'sd536870912;
      1:       v = 32'sd316933406;
      2:       v = 32'sd167458907;
      3:       v = 32'sd85004756;
      4:       v = 32'sd42667331;
      5:       v = 32'sd21354465;
      6:       v = 32'sd10679838;
      7:       v = 32'sd5340245;
      8:       v = 32'sd2670163;
      9:       v = 32'sd1335087;
      10:      v = 32'sd667544;
      11:      v = 32'sd333772;
      12:      v = 32'sd166886;
      13:      v = 32'sd83443;
      14:      v = 32'sd41722;
      15:      v = 32'sd20861;
      16:      v = 32'sd10430;
      17:      v = 32'sd5215;
      18:      v = 32'sd2608;
      19:      v = 32'sd1304;
      20:      v = 32'sd652;
      21:      v = 32'sd326;
      22:      v = 32'sd163;
      23:      v = 32'sd81;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> src/dtdc_if.sv
// Channel interfaces: input samples, compensated duties, register writes.
// Depends on dtdc_pkg for widths.
`default_nettype none

interface dtdc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] current_d;
  logic signed [15:0] current_q;
  logic signed [31:0] elec_speed;
  logic [15:0]        rotor_angle;
  logic [15:0]        duty_raw_a;
  logic [15:0]        duty_raw_b;
  logic [15:0]        duty_raw_c;
  modport source (output valid, current_d, current_q, elec_speed, rotor_angle,
                  duty_raw_a, duty_raw_b, duty_raw_c, input ready);
  modport sink (input valid, current_d, current_q, elec_speed, rotor_angle,
                duty_raw_a, duty_raw_b, duty_raw_c, output ready);
endinterface

interface dtdc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] duty_comp_a;
  logic [15:0] duty_comp_b;
  logic [15:0] duty_comp_c;
  modport source (output valid, duty_comp_a, duty_comp_b, duty_comp_c, input ready);
  modport sink (input valid, duty_comp_a, duty_comp_b, duty_comp_c, output ready);
endinterface

interface dtdc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [dtdc_pkg::CFG_IDX_W-1:0]   index;
  logic [dtdc_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/dead_time_duty_compensation.sv
// Top level of the dead-time duty compensation block.
// Depends on dtdc_pkg, dtdc_if, dtdc_cordic_cell and dtdc_xform.
//
// Usage:
//   sample : input channel (valid/ready) carrying d/q currents, electrical
//            speed, rotor angle and the three raw duties.
//   result : output channel (valid/ready) carrying the three compensated duties.
//   cfg    : register write channel, always ready; index selects dead-time
//            duty, speed threshold, lead gain or current deadband. Unknown
//            indexes are dropped. Write only while no transaction is in flight.
// Throughput: one transaction per clock while the skid entry is free.
// Pipeline: from acceptance to result valid the data pass the input register,
//   the speed*gain multiply, one cell per CORDIC rotation, then six transform
//   stages (fold, four products, alpha/beta, sqrt(3)/2 product, phase b,
//   phase c) and the output register.
// Stall: an output register plus one skid entry sit at the end; the whole
//   pipeline holds while the skid entry is full, so sample.ready comes
//   straight from a flop and never depends combinationally on result.ready.
// Reset (synchronous, active high): empties the pipeline and restores the
//   register defaults (655, 212989870, 1, 410).
`default_nettype none

module dead_time_duty_compensation (
  input  logic              clk,
  input  logic              rst,
  dtdc_in_if.sink           sample,
  dtdc_out_if.source        result,
  dtdc_cfg_if.sink          cfg
);

  localparam int N = dtdc_pkg::TRIG_STAGES;

  // ---------------------------------------------------------------- config
  logic [15:0]        dt_duty;
  logic signed [31:0] speed_threshold;
  logic [15:0]        lead_gain;
  logic [14:0]        current_deadband;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dt_duty          <= 16'd655;
      speed_threshold  <= 32'sd212989870;
      lead_gain        <= 16'd1;
      current_deadband <= 15'd410;
    end else if (cfg.valid) begin
      case (cfg.index)
        dtdc_pkg::REG_DEAD_TIME_DUTY:   dt_duty          <= cfg.data[15:0];
        dtdc_pkg::REG_SPEED_THRESHOLD:  speed_threshold  <= signed'(cfg.data[31:0]);
        dtdc_pkg::REG_LEAD_GAIN:        lead_gain        <= cfg.data[15:0];
        dtdc_pkg::REG_CURRENT_DEADBAND: current_deadband <= cfg.data[14:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------ flow control
  // Advance every stage before the output register while the skid entry is free.
  logic en;
  logic skid_full;

  assign en           = ~skid_full;
  assign sample.ready = en;

  // ------------------------------------------------ stage A: input register
  logic                a_valid;
  logic signed [31:0]  a_speed;
  dtdc_pkg::angle_t    a_angle;
  logic signed [15:0]  a_d;
  logic signed [15:0]  a_q;
  dtdc_pkg::duty_t     a_duty;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_speed  <= sample.elec_speed;
      a_angle  <= dtdc_pkg::angle_t'(sample.rotor_angle);
      a_d      <= sample.current_d;
      a_q      <= sample.current_q;
      a_duty.a <= sample.duty_raw_a;
      a_duty.b <= sample.duty_raw_b;
      a_duty.c <= sample.duty_raw_c;
    end
  end

  // ------------------------------- stage B: angle lead product, speed gate
  logic                b_valid;
  logic signed [47:0]  b_prod;
  dtdc_pkg::angle_t    b_angle;
  dtdc_pkg::side_t     b_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_prod           <= 48'(a_speed) * 48'(signed'({1'b0, lead_gain}));
      b_angle          <= a_angle;
      b_side.current_d <= a_d;
      b_side.current_q <= a_q;
      b_side.duty      <= a_duty;
      b_side.comp_en   <= a_speed > speed_threshold;
    end
  end

  // ---------------------- advanced angle, folded into quadrants I and IV
  // Only the low ANGLE_BITS of the floored advance survive the wrap.
  dtdc_pkg::angle_t   turn;
  logic [31:0]        turn32;
  logic               flip;
  dtdc_pkg::cord_t    cell_in;

  always_comb begin
    turn            = b_angle + dtdc_pkg::angle_t'(b_prod[16 +: dtdc_pkg::ANGLE_BITS]);
    turn32          = {turn, {(32 - dtdc_pkg::ANGLE_BITS){1'b0}}};
    flip            = turn32[31] ^ turn32[30];
    cell_in.x       = dtdc_pkg::CORDIC_X0;
    cell_in.y       = 32'sd0;
    cell_in.z       = signed'({turn32[31] ^ flip, turn32[30:0]});
    cell_in.flip    = flip;
    cell_in.side    = b_side;
  end

  // ------------------------------------------------ CORDIC row of cells
  logic            cell_valid [N+1];
  dtdc_pkg::cord_t cell_data  [N+1];

  assign cell_valid[0] = b_valid;
  assign cell_data[0]  = cell_in;

  for (genvar g = 0; g < N; g++) begin : g_cell
    dtdc_cordic_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .stage     (dtdc_pkg::stage_t'(g)),
      .in_valid  (cell_valid[g]),
      .in_data   (cell_data[g]),
      .out_valid (cell_valid[g+1]),
      .out_data  (cell_data[g+1])
    );
  end

  // ------------------------------- current prediction and compensation
  logic            x_valid;
  dtdc_pkg::duty_t x_data;

  dtdc_xform u_xform (
    .clk              (clk),
    .rst              (rst),
    .en               (en),
    .in_valid         (cell_valid[N]),
    .in_data          (cell_data[N]),
    .dt_duty          (dt_duty),
    .current_deadband (current_deadband),
    .out_valid        (x_valid),
    .out_data         (x_data)
  );

  // ---------------------------------------- output register and skid
  logic            out_valid;
  dtdc_pkg::duty_t out_data;
  dtdc_pkg::duty_t skid_data;
  logic            push;
  logic            out_free;

  assign push     = en & x_valid;
  assign out_free = ~out_valid | result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (out_free) begin
      out_valid <= skid_full | push;
      skid_full <= 1'b0;
    end else if (push) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= skid_full ? skid_data : x_data;
    end else if (push) begin
      skid_data <= x_data;
    end
  end

  assign result.valid       = out_valid;
  assign result.duty_comp_a = out_data.a;
  assign result.duty_comp_b = out_data.b;
  assign result.duty_comp_c = out_data.c;

endmodule

`default_nettype wire

>>> src/dtdc_cordic_cell.sv
// One CORDIC rotation cell of the sine/cosine row.
// Depends on dtdc_pkg (cord_t, stage_t, atan_turn).
`default_nettype none

module dtdc_cordic_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  dtdc_pkg::stage_t stage,
  input  logic            in_valid,
  input  dtdc_pkg::cord_t in_data,
  output logic            out_valid,
  output dtdc_pkg::cord_t out_data
);

  logic signed [31:0] dx;
  logic signed [31:0] dy;
  logic signed [31:0] ang;
  dtdc_pkg::cord_t    data_next;

  // Rotate towards zero residual angle.
  always_comb begin
    dx        = in_data.y >>> stage;
    dy        = in_data.x >>> stage;
    ang       = dtdc_pkg::atan_turn(stage);
    data_next = in_data;
    if (!in_data.z[31]) begin
      data_next.x = in_data.x - dx;
      data_next.y = in_data.y + dy;
      data_next.z = in_data.z - ang;
    end else begin
      data_next.x = in_data.x + dx;
      data_next.y = in_data.y - dy;
      data_next.z = in_data.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire

>>> src/dtdc_xform.sv
// Inverse Park/Clarke prediction of phase currents and duty adjustment.
// Depends on dtdc_pkg (cord_t, side_t, duty_t, SQRT3_HALF_Q30).
`default_nettype none

module dtdc_xform (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  dtdc_pkg::cord_t in_data,
  input  logic [15:0]     dt_duty,
  input  logic [14:0]     current_deadband,
  output logic            out_valid,
  output dtdc_pkg::duty_t out_data
);

  function automatic logic [15:0] adjust(input logic [15:0] raw,
                                         input logic signed [21:0] cur,
                                         input logic [15:0] dt,
                                         input logic [14:0] db);
    logic [16:0]        up;
    logic [16:0]        dn;
    logic signed [21:0] dbs;
    logic [15:0]        v;
    up  = {1'b0, raw} + {1'b0, dt};
    dn  = {1'b0, raw} - {1'b0, dt};
    dbs = signed'(22'(db));
    v   = raw;
    if (cur > dbs) begin
      v = up[16] ? 16'hFFFF : up[15:0];
    end else if (cur < -dbs) begin
      v = dn[16] ? 16'h0000 : dn[15:0];
    end
    return v;
  endfunction

  logic [5:0]             vld;
  dtdc_pkg::side_t        side [6];

  logic signed [31:0]     cs0;
  logic signed [31:0]     sn0;
  logic signed [47:0]     p_dc;
  logic signed [47:0]     p_qs;
  logic signed [47:0]     p_ds;
  logic signed [47:0]     p_qc;
  logic signed [18:0]     alpha2;
  logic signed [18:0]     beta2;
  logic signed [49:0]     pb3;
  logic signed [18:0]     alpha3;
  logic signed [18:0]     ia4;
  logic signed [20:0]     ib4;
  logic signed [21:0]     ia5;
  logic signed [21:0]     ib5;
  logic signed [21:0]     ic5;

  logic signed [48:0]     alpha_full;
  logic signed [48:0]     beta_full;
  logic signed [50:0]     ib_full;

  always_comb begin
    alpha_full = 49'(p_dc) - 49'(p_qs);
    beta_full  = 49'(p_ds) + 49'(p_qc);
    ib_full    = 51'(pb3) - (51'(alpha3) <<< 29);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // undo the half-turn fold
      cs0     <= in_data.flip ? -in_data.x : in_data.x;
      sn0     <= in_data.flip ? -in_data.y : in_data.y;
      side[0] <= in_data.side;

      p_dc    <= 48'(side[0].current_d) * 48'(cs0);
      p_qs    <= 48'(side[0].current_q) * 48'(sn0);
      p_ds    <= 48'(side[0].current_d) * 48'(sn0);
      p_qc    <= 48'(side[0].current_q) * 48'(cs0);
      side[1] <= side[0];

      alpha2  <= 19'(alpha_full >>> 30);
      beta2   <= 19'(beta_full >>> 30);
      side[2] <= side[1];

      pb3     <= 50'(beta2) * 50'(dtdc_pkg::SQRT3_HALF_Q30);
      alpha3  <= alpha2;
      side[3] <= side[2];

      ia4     <= alpha3;
      ib4     <= 21'(ib_full >>> 30);
      side[4] <= side[3];

      ia5     <= 22'(ia4);
      ib5     <= 22'(ib4);
      ic5     <= -(22'(ia4) + 22'(ib4));
      side[5] <= side[4];
    end
  end

  always_comb begin
    out_valid = vld[5];
    out_data  = side[5].duty;
    if (side[5].comp_en) begin
      out_data.a = adjust(side[5].duty.a, ia5, dt_duty, current_deadband);
      out_data.b = adjust(side[5].duty.b, ib5, dt_duty, current_deadband);
      out_data.c = adjust(side[5].duty.c, ic5, dt_duty, current_deadband);
    end
  end

endmodule

`default_nettype wire

>>> src/dtdc_checker.sv
// Port-level checks for the dead-time duty compensation block, bound to the top.
// Depends on dead_time_duty_compensation_defines.svh.
`default_nettype none
`include "dead_time_duty_compensation_defines.svh"

module dtdc_checker (
  input logic        clk,
  input logic        rst,
  input logic        sample_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [15:0] duty_comp_a,
  input logic [15:0] duty_comp_b,
  input logic [15:0] duty_comp_c
);

  `DTDC_ASSERT(a_result_hold, clk, rst, result_valid && !result_ready |=> result_valid && $stable(duty_comp_a) && $stable(duty_comp_b) && $stable(duty_comp_c), "result changed while stalled")
  `DTDC_ASSERT(a_stall_has_result, clk, rst, !sample_ready |-> result_valid, "input held off with no result pending")
  `DTDC_ASSERT(a_stall_recovers, clk, rst, !sample_ready && result_ready |=> sample_ready, "input not released after result taken")
  `DTDC_ASSERT_ALWAYS(a_reset_empty, clk, $fell(rst) |-> !result_valid && sample_ready, "pipeline not empty after reset")

endmodule

bind dead_time_duty_compensation dtdc_checker u_dtdc_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_ready (sample.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .duty_comp_a  (result.duty_comp_a),
  .duty_comp_b  (result.duty_comp_b),
  .duty_comp_c  (result.duty_comp_c)
);

`default_nettype wire
